FILE: design/jbt_pkg.sv
// Shared constants, codes and byte classes for the JSON byte tokenizer.
package jbt_pkg;

  localparam int unsigned LineBitsDef = 20;
  localparam int unsigned ColumnBitsDef = 16;
  localparam int unsigned LengthBitsDef = 16;

  localparam int unsigned MaxRec = 3;
  localparam int unsigned CntW = 2;

  typedef enum logic [1:0] {
    REC_LITERAL = 2'd0,
    REC_DONE    = 2'd1,
    REC_ERROR   = 2'd2,
    REC_END     = 2'd3
  } rec_kind_e;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_STRING  = 2'd1;
  localparam logic [1:0] MODE_NUMBER  = 2'd2;
  localparam logic [1:0] MODE_KEYWORD = 2'd3;

  localparam logic [3:0] TK_NONE     = 4'd0;
  localparam logic [3:0] TK_STRING   = 4'd0;
  localparam logic [3:0] TK_NUMBER   = 4'd1;
  localparam logic [3:0] TK_TRUE     = 4'd2;
  localparam logic [3:0] TK_FALSE    = 4'd3;
  localparam logic [3:0] TK_NULL     = 4'd4;
  localparam logic [3:0] TK_COMMA    = 4'd5;
  localparam logic [3:0] TK_COLON    = 4'd6;
  localparam logic [3:0] TK_PLUS     = 4'd7;
  localparam logic [3:0] TK_MINUS    = 4'd8;
  localparam logic [3:0] TK_LBRACKET = 4'd9;
  localparam logic [3:0] TK_RBRACKET = 4'd10;
  localparam logic [3:0] TK_LBRACE   = 4'd11;
  localparam logic [3:0] TK_RBRACE   = 4'd12;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNTERM     = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX    = 3'd2;
  localparam logic [2:0] ERR_BAD_KWORD  = 3'd3;
  localparam logic [2:0] ERR_BAD_PUNCT  = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd5;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return ((b >= 8'h21) && (b <= 8'h2F)) || ((b >= 8'h3A) && (b <= 8'h40)) ||
           ((b >= 8'h5B) && (b <= 8'h60)) || ((b >= 8'h7B) && (b <= 8'h7E));
  endfunction

  function automatic logic is_ident(input logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == 8'h5F) || (b == 8'h24) || b[7];
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] r;
    case (k)
      2'd1:    r = 3'd5;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      2'd0: begin
        case (pos)
          3'd0: r = 8'h74;
          3'd1: r = 8'h72;
          3'd2: r = 8'h75;
          3'd3: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: r = 8'h66;
          3'd1: r = 8'h61;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h73;
          3'd4: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0: r = 8'h6E;
          3'd1: r = 8'h75;
          3'd2: r = 8'h6C;
          3'd3: r = 8'h6C;
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/jbt_lexer.sv
// Lexer state and per-byte record generation for the JSON byte tokenizer.
module jbt_lexer import jbt_pkg::*; #(
  parameter int unsigned LINE_BITS = LineBitsDef,
  parameter int unsigned COLUMN_BITS = ColumnBitsDef,
  parameter int unsigned LENGTH_BITS = LengthBitsDef,
  localparam int unsigned RecW = 2 + 4 + 8 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [7:0]                     byte_i,
  input  logic                           eoi_i,
  output logic [MaxRec-1:0][RecW-1:0]    recs_o,
  output logic [CntW-1:0]                count_o
);

  localparam logic [LINE_BITS-1:0] LineOne = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] ColOne = COLUMN_BITS'(1);

  logic [1:0]             mode_q, mode_d;
  logic [2:0]             esc_q, esc_d;
  logic                   exps_q, exps_d;
  logic                   pexp_q, pexp_d;
  logic [2:0]             kw_q, kw_d;
  logic [1:0]             utf_q, utf_d;
  logic                   fail_q, fail_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [LINE_BITS-1:0]   tline_q, tline_d;
  logic [COLUMN_BITS-1:0] tcol_q, tcol_d;
  logic [LENGTH_BITS-1:0] tlen_q, tlen_d;

  function automatic logic [RecW-1:0] mk(input logic [1:0] kind, input logic [3:0] tk,
                                         input logic [7:0] b,
                                         input logic [LINE_BITS-1:0] ln,
                                         input logic [COLUMN_BITS-1:0] cl,
                                         input logic [LENGTH_BITS-1:0] nb,
                                         input logic [2:0] err);
    return {err, nb, cl, ln, b, tk, kind};
  endfunction

  function automatic logic [3:0] kw_kind(input logic [2:0] dead,
                                         input logic [LENGTH_BITS-1:0] len);
    logic [3:0] r;
    r = TK_NONE;
    if (!dead[0] && (len == LENGTH_BITS'(4))) r = TK_TRUE;
    else if (!dead[1] && (len == LENGTH_BITS'(5))) r = TK_FALSE;
    else if (!dead[2] && (len == LENGTH_BITS'(4))) r = TK_NULL;
    return r;
  endfunction

  logic [MaxRec-1:0][RecW-1:0] recs;
  logic [CntW-1:0]             n;
  logic                        do_idle;
  logic                        is_e;
  logic [3:0]                  pk;
  logic [3:0]                  kk;
  logic                        cont;
  logic [7:0]                  b;

  always_comb begin
    mode_d = mode_q; esc_d = esc_q; exps_d = exps_q; pexp_d = pexp_q; kw_d = kw_q;
    utf_d = utf_q; fail_d = fail_q; line_d = line_q; col_d = col_q;
    tline_d = tline_q; tcol_d = tcol_q; tlen_d = tlen_q;
    recs = '0;
    n = '0;
    do_idle = 1'b0;
    b = byte_i;
    is_e = (b == 8'h65) || (b == 8'h45);
    pk = TK_NONE;
    kk = TK_NONE;
    cont = 1'b0;

    if (!fail_q) begin
      case (mode_q)
        MODE_STRING: begin
          if (esc_q == 3'd1) begin
            if ((b == 8'h0A) || (b == 8'hFF)) begin
              recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, tline_d, tcol_d, '0, ERR_UNTERM);
              n = n + 1'b1;
              fail_d = 1'b1; mode_d = MODE_IDLE; esc_d = 3'd0;
            end else begin
              if (tlen_d != '1) tlen_d = tlen_d + 1'b1;
              recs[n] = mk(REC_LITERAL, TK_NONE, b, tline_d, tcol_d, '0, ERR_NONE);
              n = n + 1'b1;
              esc_d = (b == 8'h75) ? 3'd5 : 3'd0;
            end
          end else if ((esc_q >= 3'd2) && (esc_q <= 3'd5)) begin
            if (is_hex(b)) begin
              if (tlen_d != '1) tlen_d = tlen_d + 1'b1;
              recs[n] = mk(REC_LITERAL, TK_NONE, b, tline_d, tcol_d, '0, ERR_NONE);
              n = n + 1'b1;
              esc_d = (esc_q == 3'd2) ? 3'd0 : esc_q - 3'd1;
            end else begin
              recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, tline_d, tcol_d, '0, ERR_BAD_HEX);
              n = n + 1'b1;
              fail_d = 1'b1; mode_d = MODE_IDLE; esc_d = 3'd0;
            end
          end else if (b == 8'h22) begin
            recs[n] = mk(REC_DONE, TK_STRING, 8'h00, tline_d, tcol_d, tlen_d, ERR_NONE);
            n = n + 1'b1;
            mode_d = MODE_IDLE; esc_d = 3'd0;
          end else if ((b == 8'h0A) || (b == 8'hFF)) begin
            recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, tline_d, tcol_d, '0, ERR_UNTERM);
            n = n + 1'b1;
            fail_d = 1'b1; mode_d = MODE_IDLE; esc_d = 3'd0;
          end else begin
            if (tlen_d != '1) tlen_d = tlen_d + 1'b1;
            recs[n] = mk(REC_LITERAL, TK_NONE, b, tline_d, tcol_d, '0, ERR_NONE);
            n = n + 1'b1;
            esc_d = (b == 8'h5C) ? 3'd1 : 3'd0;
          end
        end
        MODE_NUMBER: begin
          if (is_digit(b) || (b == 8'h2E) || (!exps_q && is_e) ||
              (pexp_q && ((b == 8'h2B) || (b == 8'h2D)))) begin
            pexp_d = is_e;
            if (is_e) exps_d = 1'b1;
            if (tlen_d != '1) tlen_d = tlen_d + 1'b1;
            recs[n] = mk(REC_LITERAL, TK_NONE, b, tline_d, tcol_d, '0, ERR_NONE);
            n = n + 1'b1;
          end else begin
            recs[n] = mk(REC_DONE, TK_NUMBER, 8'h00, tline_d, tcol_d, tlen_d, ERR_NONE);
            n = n + 1'b1;
            mode_d = MODE_IDLE;
            do_idle = 1'b1;
          end
        end
        MODE_KEYWORD: begin
          if (is_ident(b)) begin
            for (int k = 0; k < 3; k++) begin
              if (!kw_q[k] && ((tlen_q >= LENGTH_BITS'(kw_len(2'(k)))) ||
                               (kw_char(2'(k), tlen_q[2:0]) != b))) begin
                kw_d[k] = 1'b1;
              end
            end
            if (tlen_d != '1) tlen_d = tlen_d + 1'b1;
            recs[n] = mk(REC_LITERAL, TK_NONE, b, tline_d, tcol_d, '0, ERR_NONE);
            n = n + 1'b1;
          end else begin
            mode_d = MODE_IDLE;
            kk = kw_kind(kw_q, tlen_q);
            if (kk != TK_NONE) begin
              recs[n] = mk(REC_DONE, kk, 8'h00, tline_d, tcol_d, tlen_d, ERR_NONE);
              n = n + 1'b1;
              do_idle = 1'b1;
            end else begin
              recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, tline_d, tcol_d, '0, ERR_BAD_KWORD);
              n = n + 1'b1;
              fail_d = 1'b1; esc_d = 3'd0;
            end
          end
        end
        default: begin
          mode_d = MODE_IDLE;
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        if (is_digit(b)) begin
          mode_d = MODE_NUMBER; tline_d = line_q; tcol_d = col_q; tlen_d = LENGTH_BITS'(1);
          esc_d = 3'd0; exps_d = 1'b0; pexp_d = 1'b0; kw_d = 3'd0;
          recs[n] = mk(REC_LITERAL, TK_NONE, b, line_q, col_q, '0, ERR_NONE);
          n = n + 1'b1;
        end else if (b == 8'h22) begin
          mode_d = MODE_STRING; tline_d = line_q; tcol_d = col_q; tlen_d = '0;
          esc_d = 3'd0; exps_d = 1'b0; pexp_d = 1'b0; kw_d = 3'd0;
        end else if (is_punct(b)) begin
          case (b)
            8'h2C:   pk = TK_COMMA;
            8'h3A:   pk = TK_COLON;
            8'h2B:   pk = TK_PLUS;
            8'h2D:   pk = TK_MINUS;
            8'h5B:   pk = TK_LBRACKET;
            8'h5D:   pk = TK_RBRACKET;
            8'h7B:   pk = TK_LBRACE;
            8'h7D:   pk = TK_RBRACE;
            default: pk = TK_NONE;
          endcase
          if (pk != TK_NONE) begin
            recs[n] = mk(REC_DONE, pk, b, line_q, col_q, LENGTH_BITS'(1), ERR_NONE);
          end else begin
            recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, line_q, col_q, '0, ERR_BAD_PUNCT);
            fail_d = 1'b1; mode_d = MODE_IDLE; esc_d = 3'd0;
          end
          n = n + 1'b1;
        end else if (is_alpha(b) || (b[7] && (b != 8'hFF))) begin
          mode_d = MODE_KEYWORD; tline_d = line_q; tcol_d = col_q; tlen_d = LENGTH_BITS'(1);
          esc_d = 3'd0; exps_d = 1'b0; pexp_d = 1'b0;
          for (int k = 0; k < 3; k++) begin
            kw_d[k] = (kw_char(2'(k), 3'd0) != b);
          end
          recs[n] = mk(REC_LITERAL, TK_NONE, b, line_q, col_q, '0, ERR_NONE);
          n = n + 1'b1;
        end else if ((b == 8'h20) || (b == 8'h0D) || (b == 8'h08) || (b == 8'h09) ||
                     (b == 8'h0A)) begin
          n = n;
        end else begin
          recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, line_q, col_q, '0, ERR_UNEXPECTED);
          n = n + 1'b1;
          fail_d = 1'b1; mode_d = MODE_IDLE; esc_d = 3'd0;
        end
      end

      cont = (utf_q != 2'd0) && (b[7:6] == 2'b10);
      if (b == 8'h0A) begin
        if (line_d != '1) line_d = line_d + 1'b1;
        col_d = ColOne;
        utf_d = 2'd0;
      end else if (cont) begin
        utf_d = utf_q - 2'd1;
      end else begin
        if (col_d != '1) col_d = col_d + 1'b1;
        if (b[7:3] == 5'b11110) utf_d = 2'd3;
        else if (b[7:4] == 4'hE) utf_d = 2'd2;
        else if (b[7:5] == 3'b110) utf_d = 2'd1;
        else utf_d = 2'd0;
      end
    end

    if (eoi_i) begin
      if (!fail_d) begin
        if (mode_d == MODE_NUMBER) begin
          recs[n] = mk(REC_DONE, TK_NUMBER, 8'h00, tline_d, tcol_d, tlen_d, ERR_NONE);
          n = n + 1'b1;
        end else if (mode_d == MODE_KEYWORD) begin
          kk = kw_kind(kw_d, tlen_d);
          if (kk != TK_NONE) begin
            recs[n] = mk(REC_DONE, kk, 8'h00, tline_d, tcol_d, tlen_d, ERR_NONE);
          end else begin
            recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, tline_d, tcol_d, '0, ERR_BAD_KWORD);
          end
          n = n + 1'b1;
        end else if (mode_d == MODE_STRING) begin
          recs[n] = mk(REC_ERROR, TK_NONE, 8'h00, tline_d, tcol_d, '0, ERR_UNTERM);
          n = n + 1'b1;
        end
      end
      // drop the end record when the bank is already full
      if (n != CntW'(MaxRec)) begin
        recs[n] = mk(REC_END, TK_NONE, 8'h00, line_d, col_d, '0, ERR_NONE);
        n = n + 1'b1;
      end
      mode_d = MODE_IDLE; esc_d = 3'd0; exps_d = 1'b0; pexp_d = 1'b0; kw_d = 3'd0;
      utf_d = 2'd0; fail_d = 1'b0; line_d = LineOne; col_d = ColOne;
      tline_d = LineOne; tcol_d = ColOne; tlen_d = '0;
    end
  end

  assign recs_o = recs;
  assign count_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; esc_q <= 3'd0; exps_q <= 1'b0; pexp_q <= 1'b0; kw_q <= 3'd0;
      utf_q <= 2'd0; fail_q <= 1'b0; line_q <= LineOne; col_q <= ColOne;
      tline_q <= LineOne; tcol_q <= ColOne; tlen_q <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d; esc_q <= esc_d; exps_q <= exps_d; pexp_q <= pexp_d; kw_q <= kw_d;
      utf_q <= utf_d; fail_q <= fail_d; line_q <= line_d; col_q <= col_d;
      tline_q <= tline_d; tcol_q <= tcol_d; tlen_q <= tlen_d;
    end
  end

endmodule

FILE: design/jbt_outq.sv
// Result register bank that holds the records of one byte and drains one per beat.
module jbt_outq import jbt_pkg::*; #(
  parameter int unsigned RecW = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [MaxRec-1:0][RecW-1:0]  recs_i,
  input  logic [CntW-1:0]              count_i,
  input  logic                         pop_i,
  output logic                         room_o,
  output logic                         valid_o,
  output logic [RecW-1:0]              rec_o,
  output logic                         last_o
);

  logic [MaxRec-1:0][RecW-1:0] slot_q, slot_d;
  logic [CntW-1:0]             cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign rec_o = slot_q[0];
  assign last_o = (cnt_q == CntW'(1));
  assign room_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && pop_i);

  always_comb begin
    slot_d = slot_q;
    cnt_d = cnt_q;
    if (pop_i && valid_o) begin
      for (int i = 0; i < MaxRec - 1; i++) begin
        slot_d[i] = slot_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
    if (load_i) begin
      slot_d = recs_i;
      cnt_d = count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRec)) else $error("record count out of range");
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> ((cnt_q == '0) || (cnt_q == CntW'(1) && pop_i)))
    else $error("load over pending records");
  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (cnt_q == $past(count_i))) else $error("count lost on load");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && valid_o && !load_i) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("drain did not advance");
`endif

endmodule

FILE: design/json_byte_tokenizer.sv
// JSON byte tokenizer top level: input stream, lexer and result stream.
//
// Input stream: one byte of JSON text per beat in s_axis_tdata_i; s_axis_tlast_i
// marks the final byte of a document. Output stream: one record per beat,
// record kind in m_axis_tuser_o, fields in m_axis_tdata_o, and m_axis_tlast_o
// on the last record caused by a given input byte.
// Records of a byte are registered and appear the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one record and
// the receiver is ready; a byte yielding k records holds the input while the
// single output port drains the result register bank one record per beat.
// Bytes that yield no record (whitespace, opening quotes) leave the bank empty.
// Reset: lexer returns to idle between tokens at line 1, column 1, the result
// bank empties and no record is shown.
// When the receiver stalls, the current record holds and the input takes a new
// byte only once the last pending record is leaving.
module json_byte_tokenizer import jbt_pkg::*; #(
  parameter int unsigned LINE_BITS = LineBitsDef,
  parameter int unsigned COLUMN_BITS = ColumnBitsDef,
  parameter int unsigned LENGTH_BITS = LengthBitsDef,
  localparam int unsigned RecW = 2 + 4 + 8 + LINE_BITS + COLUMN_BITS + LENGTH_BITS + 3,
  localparam int unsigned TDataW = ((RecW - 2 + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [7:0]        s_axis_tdata_i,   // data_byte
  input  logic              s_axis_tlast_i,
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // token_kind, byte_out, start_line, start_column, token_bytes, error_code
  output logic [TDataW-1:0] m_axis_tdata_o,
  output logic [1:0]        m_axis_tuser_o,   // record_kind
  output logic              m_axis_tlast_o
);

  logic                        accept;
  logic [MaxRec-1:0][RecW-1:0] recs;
  logic [CntW-1:0]             count;
  logic                        room;
  logic [RecW-1:0]             rec;

  assign accept = s_axis_tvalid_i && room;
  assign s_axis_tready_o = room;

  jbt_lexer #(
    .LINE_BITS(LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_lexer (
    .clk_i,
    .rst_ni,
    .accept_i(accept),
    .byte_i(s_axis_tdata_i),
    .eoi_i(s_axis_tlast_i),
    .recs_o(recs),
    .count_o(count)
  );

  jbt_outq #(
    .RecW(RecW)
  ) u_outq (
    .clk_i,
    .rst_ni,
    .load_i(accept),
    .recs_i(recs),
    .count_i(count),
    .pop_i(m_axis_tready_i),
    .room_o(room),
    .valid_o(m_axis_tvalid_o),
    .rec_o(rec),
    .last_o(m_axis_tlast_o)
  );

  assign m_axis_tuser_o = rec[1:0];
  assign m_axis_tdata_o = TDataW'(rec[RecW-1:2]);

endmodule

FILE: dv/jbt_checker.sv
// Checker for the JSON byte tokenizer: predicts records from accepted bytes and compares.
module jbt_checker import jbt_pkg::*; #(
  parameter int unsigned TDataW = 72
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              s_axis_tready_i,
  input  logic [7:0]        s_axis_tdata_i,
  input  logic              s_axis_tlast_i,
  input  logic              m_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  logic [TDataW-1:0] m_axis_tdata_i,
  input  logic [1:0]        m_axis_tuser_i,
  input  logic              m_axis_tlast_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                records_o,
  output int                errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  rkind;
    logic [3:0]  tkind;
    logic [7:0]  bval;
    logic [19:0] line;
    logic [15:0] col;
    logic [15:0] nbytes;
    logic [2:0]  err;
    logic        last;
  } jrec_t;

  jrec_t want_q[$];
  jrec_t step_q[$];

  logic [1:0]  mode;
  logic [2:0]  esc;
  logic        exp_seen, prev_exp, failed;
  logic [2:0]  kw_dead;
  logic [1:0]  utf_left;
  logic [19:0] cur_line, tok_line;
  logic [15:0] cur_col, tok_col, tok_len;

  task automatic clear_state();
    mode = MODE_IDLE; esc = 0; exp_seen = 0; prev_exp = 0; failed = 0;
    kw_dead = 0; utf_left = 0; cur_line = 1; cur_col = 1; tok_line = 1;
    tok_col = 1; tok_len = 0;
  endtask

  task automatic push(logic [1:0] rk, logic [3:0] tk, logic [7:0] b, logic [19:0] l,
                      logic [15:0] c, logic [15:0] n, logic [2:0] e);
    jrec_t r;
    r = '{rk, tk, b, l, c, n, e, 1'b0};
    if (step_q.size() < MaxRec) step_q = {step_q, r};
  endtask

  task automatic raise(logic [2:0] code, logic [19:0] l, logic [15:0] c);
    push(REC_ERROR, TK_NONE, 8'h00, l, c, 0, code);
    failed = 1; mode = MODE_IDLE; esc = 0;
  endtask

  task automatic add_lit(logic [7:0] b);
    if (tok_len != 16'hFFFF) tok_len++;
    push(REC_LITERAL, TK_NONE, b, tok_line, tok_col, 0, ERR_NONE);
  endtask

  task automatic begin_tok(logic [1:0] m, logic [19:0] l, logic [15:0] c);
    mode = m; tok_line = l; tok_col = c; tok_len = 0; esc = 0;
    exp_seen = 0; prev_exp = 0; kw_dead = 0;
  endtask

  function automatic logic dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic alph(logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic hexd(logic [7:0] b);
    return dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic punc(logic [7:0] b);
    return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
           (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
  endfunction

  task automatic kw_byte(logic [7:0] b);
    string words[3];
    int pos;
    words = '{"true", "false", "null"};
    pos = tok_len;
    for (int k = 0; k < 3; k++)
      if (!kw_dead[k] && (pos >= words[k].len() || words[k][pos] != b)) kw_dead[k] = 1;
    add_lit(b);
  endtask

  task automatic end_kw();
    string words[3];
    words = '{"true", "false", "null"};
    mode = MODE_IDLE;
    for (int k = 0; k < 3; k++)
      if (!kw_dead[k] && tok_len == words[k].len()) begin
        push(REC_DONE, 4'(TK_TRUE + k), 0, tok_line, tok_col, tok_len, ERR_NONE);
        return;
      end
    raise(ERR_BAD_KWORD, tok_line, tok_col);
  endtask

  task automatic between_tokens(logic [7:0] b, logic [19:0] l, logic [15:0] c);
    logic [3:0] k;
    if (dig(b)) begin
      begin_tok(MODE_NUMBER, l, c); add_lit(b);
    end else if (b == "\"") begin
      begin_tok(MODE_STRING, l, c);
    end else if (punc(b)) begin
      case (b)
        ",": k = TK_COMMA;
        ":": k = TK_COLON;
        "+": k = TK_PLUS;
        "-": k = TK_MINUS;
        "[": k = TK_LBRACKET;
        "]": k = TK_RBRACKET;
        "{": k = TK_LBRACE;
        "}": k = TK_RBRACE;
        default: k = TK_NONE;
      endcase
      if (k != TK_NONE) push(REC_DONE, k, b, l, c, 1, ERR_NONE);
      else raise(ERR_BAD_PUNCT, l, c);
    end else if (alph(b) || (b[7] && b != 8'hFF)) begin
      begin_tok(MODE_KEYWORD, l, c); kw_byte(b);
    end else if (!(b == 8'h20 || b == 8'h0D || b == 8'h08 || b == 8'h09 || b == 8'h0A)) begin
      raise(ERR_UNEXPECTED, l, c);
    end
  endtask

  task automatic in_string(logic [7:0] b);
    if (esc == 1) begin
      if (b == 8'h0A || b == 8'hFF) raise(ERR_UNTERM, tok_line, tok_col);
      else begin
        add_lit(b); esc = (b == "u") ? 5 : 0;
      end
    end else if (esc >= 2) begin
      if (hexd(b)) begin
        add_lit(b); esc = (esc == 2) ? 0 : esc - 1;
      end else raise(ERR_BAD_HEX, tok_line, tok_col);
    end else if (b == "\"") begin
      push(REC_DONE, TK_STRING, 0, tok_line, tok_col, tok_len, ERR_NONE);
      mode = MODE_IDLE; esc = 0;
    end else if (b == 8'h0A || b == 8'hFF) begin
      raise(ERR_UNTERM, tok_line, tok_col);
    end else begin
      add_lit(b); esc = (b == "\\") ? 1 : 0;
    end
  endtask

  task automatic track_pos(logic [7:0] b);
    if (b == 8'h0A) begin
      if (cur_line != 20'hFFFFF) cur_line++;
      cur_col = 1; utf_left = 0;
    end else if (utf_left > 0 && b[7:6] == 2'b10) begin
      utf_left--;
    end else begin
      if (cur_col != 16'hFFFF) cur_col++;
      if (b >= 8'hF0 && b < 8'hF8) utf_left = 3;
      else if (b >= 8'hE0 && b < 8'hF0) utf_left = 2;
      else if (b >= 8'hC0 && b < 8'hE0) utf_left = 1;
      else utf_left = 0;
    end
  endtask

  task automatic predict(logic [7:0] b, logic eoi);
    logic [19:0] l;
    logic [15:0] c;
    logic is_e;
    step_q.delete();
    if (!failed) begin
      l = cur_line; c = cur_col;
      is_e = (b == "e" || b == "E");
      case (mode)
        MODE_STRING: in_string(b);
        MODE_NUMBER: begin
          if (dig(b) || b == "." || (!exp_seen && is_e) || (prev_exp && (b == "+" || b == "-")))
          begin
            prev_exp = is_e;
            if (is_e) exp_seen = 1;
            add_lit(b);
          end else begin
            push(REC_DONE, TK_NUMBER, 0, tok_line, tok_col, tok_len, ERR_NONE);
            mode = MODE_IDLE;
            between_tokens(b, l, c);
          end
        end
        MODE_KEYWORD: begin
          if (is_ident(b)) kw_byte(b);
          else begin
            end_kw();
            if (!failed) between_tokens(b, l, c);
          end
        end
        default: between_tokens(b, l, c);
      endcase
      track_pos(b);
    end
    if (eoi) begin
      if (!failed) begin
        if (mode == MODE_NUMBER) begin
          push(REC_DONE, TK_NUMBER, 0, tok_line, tok_col, tok_len, ERR_NONE);
          mode = MODE_IDLE;
        end else if (mode == MODE_KEYWORD) end_kw();
        else if (mode == MODE_STRING) raise(ERR_UNTERM, tok_line, tok_col);
      end
      push(REC_END, TK_NONE, 0, cur_line, cur_col, 0, ERR_NONE);
      clear_state();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1;
    want_q = {want_q, step_q};
  endtask

  task automatic report(string what, jrec_t got, jrec_t ref_r);
    fail_count_o++;
    $display("MISMATCH %s: got %p want %p", what, got, ref_r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    jrec_t got, w;
    if (!rst_ni) begin
      clear_state();
      want_q.delete();
      fail_count_o = 0; records_o = 0; errors_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = '{m_axis_tuser_i, m_axis_tdata_i[3:0], m_axis_tdata_i[11:4],
                m_axis_tdata_i[31:12], m_axis_tdata_i[47:32], m_axis_tdata_i[63:48],
                m_axis_tdata_i[66:64], m_axis_tlast_i};
        records_o++;
        if (got.rkind == REC_ERROR) errors_o++;
        if (want_q.size() == 0) report("unexpected beat", got, got);
        else begin
          w = want_q.pop_front();
          if (got != w) report("field", got, w);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) predict(s_axis_tdata_i, s_axis_tlast_i);
      pending_o = want_q.size();
    end
  end
endmodule

FILE: dv/tb_json_byte_tokenizer.sv
// Testbench top for the JSON byte tokenizer: stimulus, stalls and verdict.
module tb_json_byte_tokenizer import jbt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TDataW = 72;
  localparam int Limit = 400000;

  logic clk_i = 0, rst_ni = 0;
  logic s_valid = 0, s_ready, s_last = 0, m_valid, m_ready = 0, m_last;
  logic [7:0] s_data = 0;
  logic [TDataW-1:0] m_data;
  logic [1:0] m_user;
  int fails, pending, records, errors, cycles = 0, sent = 0, docs = 0;
  byte unsigned doc_q[$];
  bit last_q[$];

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  json_byte_tokenizer u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  jbt_checker #(.TDataW(TDataW)) u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_i(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_i(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_i(m_data), .m_axis_tuser_i(m_user), .m_axis_tlast_i(m_last),
    .fail_count_o(fails), .pending_o(pending), .records_o(records), .errors_o(errors)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    int r;
    r = cycles % 200;
    if (r < 40) m_ready <= 1'b1;
    else m_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic add_doc(string s, bit close);
    for (int i = 0; i < s.len(); i++) begin
      doc_q = {doc_q, s[i]};
      last_q = {last_q, close && i == s.len() - 1};
    end
  endtask

  task automatic add_byte(byte unsigned b, bit l);
    doc_q = {doc_q, b};
    last_q = {last_q, l};
  endtask

  function automatic string rand_token();
    string t;
    case ($urandom_range(0, 9))
      0: t = "true";
      1: t = "false";
      2: t = "null";
      3: t = $sformatf("%0d.%0de-%0d", $urandom_range(0, 999), $urandom_range(0, 99),
                       $urandom_range(0, 9));
      4: t = $sformatf("\"a%c\\n\\u%04hB\"", $urandom_range(32, 126) == 34 ? 8'h41
                       : 8'h61, $urandom_range(0, 16'hFFFF));
      5: t = ",";
      6: t = ":";
      7: t = "{ [ ] }";
      8: t = "\n";
      default: t = "\"\xc3\xa9\xe2\x82\xac\"";
    endcase
    return t;
  endfunction

  task automatic send_all();
    int burst;
    while (doc_q.size() > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && doc_q.size() > 0) begin
        s_valid <= 1'b1;
        s_data <= doc_q.pop_front();
        s_last <= last_q.pop_front();
        @(posedge clk_i);
        while (!s_ready) @(posedge clk_i);
        sent++;
        burst--;
      end
      s_valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    add_doc("{\"k\\u0aF9\\\"\":[true,false,null,-12.5E+3]}", 1);
    add_doc("trux 0 _ $ \"ab\ncd", 1);
    add_doc("\"\\uZ\"", 1);
    add_byte(8'h00, 0); add_byte(8'h7F, 1);
    add_byte(8'hFF, 1);
    add_byte(8'h22, 0); add_byte(8'hFF, 1);
    add_doc("\"abc", 1);
    add_doc("12e3e", 1);
    add_doc("7a", 1);
    send_all();
    repeat (2) @(posedge clk_i);
    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    for (int d = 0; d < 3; d++) begin
      string doc;
      doc = "";
      for (int t = 0; t < 6; t++) doc = {doc, rand_token(), " "};
      if ($urandom_range(0, 4) == 0) doc = {doc, "@"};
      add_doc(doc, 0);
      if ($urandom_range(0, 3) == 0)
        for (int n = 0; n < 4; n++) add_byte($urandom_range(0, 255), 0);
      add_byte(8'h20, 1);
      docs++;
    end
    send_all();
    repeat (2) @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    $display("Sent %0d bytes in %0d random documents plus directed cases", sent, docs);
    $display("Checked %0d records, %0d of them errors", records, errors);
    if (fails == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
